// ===== hdl/forward_kinematics_dh6_defines.svh =====
// Assertion macros for the forward_kinematics_dh6 block.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef FORWARD_KINEMATICS_DH6_DEFINES_SVH
`define FORWARD_KINEMATICS_DH6_DEFINES_SVH

// same-cycle implication
`define FKD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fkd check failed");

// next-cycle implication
`define FKD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fkd check failed");

`endif

// ===== hdl/fkd_pkg.sv =====
// Shared constants, types and rounding helpers for forward_kinematics_dh6.
// No dependencies.
`default_nettype none
package fkd_pkg;
   localparam int ANGLE_WIDTH    = 17;
   localparam int POSITION_WIDTH = 15;
   localparam int TOOL_WIDTH     = 12;
   localparam int NUM_JOINTS     = 6;
   localparam int NUM_LANES      = 5;
   localparam int CORDIC_STEPS   = 16;
   localparam int RED_WIDTH      = ANGLE_WIDTH + 1;
   localparam int Z_WIDTH        = 24;
   localparam int TRIG_WIDTH     = 19;
   localparam int PROD_WIDTH     = 56;
   localparam int Q_WIDTH        = 34;
   localparam int REQ_WIDTH      = ((NUM_JOINTS * ANGLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_WIDTH      = ((6 * POSITION_WIDTH + 7) / 8) * 8;

   localparam logic signed [RED_WIDTH-1:0] FULL_TURN     = RED_WIDTH'(46080);
   localparam logic signed [RED_WIDTH-1:0] HALF_TURN     = RED_WIDTH'(23040);
   localparam logic signed [RED_WIDTH-1:0] QUARTER_TURN  = RED_WIDTH'(11520);
   localparam logic signed [RED_WIDTH-1:0] JOINT2_OFFSET = -RED_WIDTH'(11520);
   localparam logic signed [TRIG_WIDTH-1:0] CORDIC_START = TRIG_WIDTH'(39797);

   localparam logic signed [PROD_WIDTH-1:0] LEN_D1 = PROD_WIDTH'(2224);
   localparam logic signed [PROD_WIDTH-1:0] LEN_A3 = PROD_WIDTH'(2208);
   localparam logic signed [PROD_WIDTH-1:0] LEN_A4 = PROD_WIDTH'(1408);
   localparam logic signed [PROD_WIDTH-1:0] LEN_D4 = PROD_WIDTH'(2016);
   localparam logic signed [PROD_WIDTH-1:0] HALF_LSB = PROD_WIDTH'(32768);

   typedef struct packed {
      logic signed [TRIG_WIDTH-1:0] c;
      logic signed [TRIG_WIDTH-1:0] s;
   } sincos_type;

   typedef struct packed {
      logic signed [POSITION_WIDTH-1:0] tip_z;
      logic signed [POSITION_WIDTH-1:0] tip_y;
      logic signed [POSITION_WIDTH-1:0] tip_x;
      logic signed [POSITION_WIDTH-1:0] wrist_z;
      logic signed [POSITION_WIDTH-1:0] wrist_y;
      logic signed [POSITION_WIDTH-1:0] wrist_x;
   } result_type;

   // arctangent of 2^-i in 1/32768 degree
   function automatic logic signed [Z_WIDTH-1:0] atan_entry(input int i);
      case (i)
         0:       return Z_WIDTH'(1474560);
         1:       return Z_WIDTH'(870484);
         2:       return Z_WIDTH'(459940);
         3:       return Z_WIDTH'(233473);
         4:       return Z_WIDTH'(117189);
         5:       return Z_WIDTH'(58652);
         6:       return Z_WIDTH'(29333);
         7:       return Z_WIDTH'(14667);
         8:       return Z_WIDTH'(7334);
         9:       return Z_WIDTH'(3667);
         10:      return Z_WIDTH'(1833);
         11:      return Z_WIDTH'(917);
         12:      return Z_WIDTH'(458);
         13:      return Z_WIDTH'(229);
         14:      return Z_WIDTH'(115);
         default: return Z_WIDTH'(57);
      endcase
   endfunction

   // Q16 product back to Q16, round half up
   function automatic logic signed [PROD_WIDTH-1:0] rnd16(input logic signed [PROD_WIDTH-1:0] p);
      return (p + HALF_LSB) >>> 16;
   endfunction

   // round to whole 1/16 mm and clamp to the output range
   function automatic logic signed [POSITION_WIDTH-1:0] finish(
      input logic signed [PROD_WIDTH-1:0] q);
      logic signed [PROD_WIDTH-1:0] v;
      logic signed [PROD_WIDTH-1:0] hi;
      logic signed [PROD_WIDTH-1:0] lo;
      v  = rnd16(q);
      hi = (PROD_WIDTH'(1) <<< (POSITION_WIDTH - 1)) - PROD_WIDTH'(1);
      lo = -(PROD_WIDTH'(1) <<< (POSITION_WIDTH - 1));
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[POSITION_WIDTH-1:0];
   endfunction
endpackage
`default_nettype wire

// ===== hdl/fkd_cordic_lane.sv =====
// One sine/cosine lane: range reduction stage plus a 16-stage CORDIC pipe.
// Depends on fkd_pkg.
`default_nettype none
module fkd_cordic_lane (
   input  wire logic                                 clock,
   input  wire logic                                 en,
   input  wire logic signed [fkd_pkg::RED_WIDTH-1:0] angle,
   output fkd_pkg::sincos_type                       result
);
   import fkd_pkg::*;

   logic signed [TRIG_WIDTH-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [TRIG_WIDTH-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [Z_WIDTH-1:0]    z_ff [0:CORDIC_STEPS];
   logic                         flip_ff [0:CORDIC_STEPS];
   logic signed [RED_WIDTH-1:0]  red_in;
   logic                         flip_in;

   // fold into +-90 deg; flip marks a half-turn shift
   always_comb begin
      red_in = angle;
      if (red_in < 0) red_in = red_in + FULL_TURN;
      if (red_in < 0) red_in = red_in + FULL_TURN;
      if (red_in >= FULL_TURN) red_in = red_in - FULL_TURN;
      if (red_in >= HALF_TURN) red_in = red_in - FULL_TURN;
      flip_in = 1'b0;
      if (red_in > QUARTER_TURN) begin
         red_in  = red_in - HALF_TURN;
         flip_in = 1'b1;
      end else if (red_in < -QUARTER_TURN) begin
         red_in  = red_in + HALF_TURN;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= CORDIC_START;
         y_ff[0]    <= '0;
         z_ff[0]    <= Z_WIDTH'(red_in) <<< 8;
         flip_ff[0] <= flip_in;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][Z_WIDTH-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(i);
            end
         end
      end
   end

   assign result.c = flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
   assign result.s = flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
endmodule
`default_nettype wire

// ===== hdl/fkd_merge.sv =====
// Merge stage: combines the five lane sine/cosine pairs into wrist and tip positions.
// Five registered stages, one multiply level each. Depends on fkd_pkg.
`default_nettype none
module fkd_merge (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire logic                                in_valid,
   input  fkd_pkg::sincos_type [fkd_pkg::NUM_LANES-1:0] sc,
   input  wire logic [fkd_pkg::TOOL_WIDTH-1:0]      tool_length,
   output logic                                     out_valid,
   output fkd_pkg::result_type                      result
);
   import fkd_pkg::*;

   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [Q_WIDTH-1:0]    q_type;

   logic [4:0] vld_ff;
   sincos_type [2:0] sc_s1_ff;   // joints 1..3
   sincos_type [1:0] sc_s2_ff;   // joints 1..2
   sincos_type       sc_s3_ff;   // joint 1
   q_type px_ff, py_ff, da_ff, db_ff, dc_ff;
   q_type u_ff, v_ff, a3_ff, b3_ff;
   q_type wx3_ff, wy3_ff, wz3_ff, du_ff, dv_ff, dc3_ff, dc2_ff;
   q_type wx4_ff, wy4_ff, wz4_ff, tx_ff, ty_ff, tz_ff;
   result_type result_ff;
   prod_type c1, s1, c2, s2, c3, s3, c4, s4, c5, s5, len;

   always_comb begin
      c3 = prod_type'(sc[2].c);
      s3 = prod_type'(sc[2].s);
      c4 = prod_type'(sc[3].c);
      s4 = prod_type'(sc[3].s);
      c5 = prod_type'(sc[4].c);
      s5 = prod_type'(sc[4].s);
      c2 = prod_type'(sc_s1_ff[1].c);
      s2 = prod_type'(sc_s1_ff[1].s);
      c1 = prod_type'(sc_s3_ff.c);
      s1 = prod_type'(sc_s3_ff.s);
      len = prod_type'($signed({1'b0, tool_length}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: wrist in frame 2, tool axis in frame 3
         sc_s1_ff <= sc[2:0];
         px_ff <= q_type'((LEN_A3 <<< 16) + LEN_A4 * c3 - LEN_D4 * s3);
         py_ff <= q_type'(LEN_A4 * s3 + LEN_D4 * c3);
         da_ff <= q_type'(-rnd16(c4 * s5));
         db_ff <= q_type'(c5);
         dc_ff <= q_type'(rnd16(s4 * s5));
         // stage 2: rotate by joint 2 / joint 3
         sc_s2_ff <= sc_s1_ff[1:0];
         u_ff  <= q_type'(rnd16(c2 * prod_type'(px_ff) - s2 * prod_type'(py_ff)));
         v_ff  <= q_type'(rnd16(s2 * prod_type'(px_ff) + c2 * prod_type'(py_ff)));
         a3_ff <= q_type'(rnd16(prod_type'(sc_s1_ff[2].c) * prod_type'(da_ff)
                  - prod_type'(sc_s1_ff[2].s) * prod_type'(db_ff)));
         b3_ff <= q_type'(rnd16(prod_type'(sc_s1_ff[2].s) * prod_type'(da_ff)
                  + prod_type'(sc_s1_ff[2].c) * prod_type'(db_ff)));
         dc2_ff <= dc_ff;
         // stage 3: wrist to base, tool axis through joint 2
         sc_s3_ff <= sc_s2_ff[0];
         wx3_ff <= q_type'(rnd16(prod_type'(sc_s2_ff[0].c) * prod_type'(u_ff)));
         wy3_ff <= q_type'(rnd16(prod_type'(sc_s2_ff[0].s) * prod_type'(u_ff)));
         wz3_ff <= q_type'((LEN_D1 <<< 16) - prod_type'(v_ff));
         du_ff  <= q_type'(rnd16(prod_type'(sc_s2_ff[1].c) * prod_type'(a3_ff)
                   - prod_type'(sc_s2_ff[1].s) * prod_type'(b3_ff)));
         dv_ff  <= q_type'(rnd16(prod_type'(sc_s2_ff[1].s) * prod_type'(a3_ff)
                   + prod_type'(sc_s2_ff[1].c) * prod_type'(b3_ff)));
         dc3_ff <= dc2_ff;
         // stage 4: tool axis to base
         wx4_ff <= wx3_ff;
         wy4_ff <= wy3_ff;
         wz4_ff <= wz3_ff;
         tx_ff  <= q_type'(rnd16(c1 * prod_type'(du_ff) - s1 * prod_type'(dc3_ff)));
         ty_ff  <= q_type'(rnd16(s1 * prod_type'(du_ff) + c1 * prod_type'(dc3_ff)));
         tz_ff  <= -dv_ff;
         // stage 5: tip offset, round and clamp
         result_ff.wrist_x <= finish(prod_type'(wx4_ff));
         result_ff.wrist_y <= finish(prod_type'(wy4_ff));
         result_ff.wrist_z <= finish(prod_type'(wz4_ff));
         result_ff.tip_x   <= finish(prod_type'(wx4_ff) + len * prod_type'(tx_ff));
         result_ff.tip_y   <= finish(prod_type'(wy4_ff) + len * prod_type'(ty_ff));
         result_ff.tip_z   <= finish(prod_type'(wz4_ff) + len * prod_type'(tz_ff));
      end
   end

   assign out_valid = vld_ff[4];
   assign result    = result_ff;
endmodule
`default_nettype wire

// ===== hdl/forward_kinematics_dh6.sv =====
// forward_kinematics_dh6: six-joint modified-DH forward kinematics.
// The pipe holds 1 range-reduction stage, 16 CORDIC stages and 5 merge stages.
// Throughput one request per cycle; the whole pipe stalls only while a result waits.
// Reset (synchronous, active high) empties the pipe and clears tool_length to 0.
// Depends on fkd_pkg, fkd_cordic_lane, fkd_merge and the defines header.
`default_nettype none
`include "forward_kinematics_dh6_defines.svh"
module forward_kinematics_dh6 (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tdata: joint1_angle .. joint6_angle, 17 bits each from bit 0, zero pad
   input  wire logic [fkd_pkg::REQ_WIDTH-1:0]     req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: wrist_x, wrist_y, wrist_z, tip_x, tip_y, tip_z, 15 bits each, zero pad
   output logic [fkd_pkg::RSP_WIDTH-1:0]          rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_wr_en,
   input  wire logic [fkd_pkg::TOOL_WIDTH-1:0]    csr_wr_data
);
   import fkd_pkg::*;

   logic                         en;
   logic [TOOL_WIDTH-1:0]        tool_length_ff;
   logic [CORDIC_STEPS:0]        vld_ff;
   logic signed [RED_WIDTH-1:0]  lane_angle [NUM_LANES];
   sincos_type [NUM_LANES-1:0]   lane_sc;
   result_type                   result;

   // pipe moves whenever the output slot is empty or being drained
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         tool_length_ff <= '0;
      end else if (csr_wr_en) begin
         tool_length_ff <= csr_wr_data;
      end
   end

   // request valid follows the data through the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[CORDIC_STEPS-1:0], req_tvalid};
      end
   end

   // joint 6 does not move the tool axis, so only five lanes are built
   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         lane_angle[k] = RED_WIDTH'($signed(req_tdata[k*ANGLE_WIDTH +: ANGLE_WIDTH]));
      end
      lane_angle[1] = lane_angle[1] + JOINT2_OFFSET;
   end

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      fkd_cordic_lane u_lane (
         .clock  (clock),
         .en     (en),
         .angle  (lane_angle[k]),
         .result (lane_sc[k])
      );
   end

   fkd_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (vld_ff[CORDIC_STEPS]),
      .sc          (lane_sc),
      .tool_length (tool_length_ff),
      .out_valid   (rsp_tvalid),
      .result      (result)
   );

   assign rsp_tdata = RSP_WIDTH'(result);

   // with no pen the tip sits on the wrist centre
   `FKD_ASSERT_NOW(a_tip_is_wrist, rsp_tvalid && tool_length_ff == '0,
      result.tip_x == result.wrist_x && result.tip_y == result.wrist_y &&
      result.tip_z == result.wrist_z)
   // an empty output slot never holds off requests
   `FKD_ASSERT_NOW(a_ready_when_empty, !rsp_tvalid, req_tready)
   // a stall freezes the in-flight valid chain
   `FKD_ASSERT_NEXT(a_stall_holds, !req_tready, $stable(vld_ff))
endmodule
`default_nettype wire

// ===== sim/tb_forward_kinematics_dh6.sv =====
// Testbench for forward_kinematics_dh6: six joint angles in, wrist and tool-tip positions out.
// Checks each result against an in-bench CORDIC/DH predictor. Depends on fkd_pkg and the RTL.
`timescale 1ns / 1ps
module tb_forward_kinematics_dh6;
   import fkd_pkg::*;

   localparam int ANG_MAX = 46080;
   localparam int LATENCY = 22;

   logic                    clock;
   logic                    reset;
   logic [REQ_WIDTH-1:0]    req_tdata;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [RSP_WIDTH-1:0]    rsp_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic                    csr_wr_en;
   logic [TOOL_WIDTH-1:0]   csr_wr_data;

   forward_kinematics_dh6 uut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // Pose request: six raw encoder angles.
   typedef struct {
      logic signed [ANGLE_WIDTH-1:0] ang [6];
   } pose_type;

   // Directed row: angles plus an optional typed-in expectation.
   typedef struct {
      int          a [6];
      bit          has_fixed;
      result_type  fixed;
   } pose_row_type;

   result_type  expected_positions [$];
   int          tool_len_model;
   int          fail_count;
   int          result_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_off_cycles;   // long receiver hold-off, counted in its own process

   // ---------------------------------------------------------------- predictor
   function automatic longint fshift(longint v, int s);
      return v >>> s;  // arithmetic shift on signed longint is floor
   endfunction

   function automatic longint q16_round(longint p);
      return (p + 64'sd32768) >>> 16;
   endfunction

   // rotation-mode CORDIC, angle in 1/128 degree
   function automatic void trig_of(longint ang, output longint c, output longint s);
      longint r, x, y, z, dx, dy;
      longint atan_deg [16] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333,
                                14667, 7334, 3667, 1833, 917, 458, 229, 115, 57};
      bit flip;
      r = ang % ANG_MAX;
      if (r < 0) r += ANG_MAX;
      if (r >= 23040) r -= ANG_MAX;
      flip = 0;
      if (r > 11520) begin
         r -= 23040; flip = 1;
      end else if (r < -11520) begin
         r += 23040; flip = 1;
      end
      x = 39797; y = 0; z = r * 256;
      for (int i = 0; i < 16; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_deg[i];
         end else begin
            x += dx; y -= dy; z += atan_deg[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = x; s = y;
   endfunction

   function automatic logic signed [POSITION_WIDTH-1:0] clamp_pos(longint q);
      longint v;
      v = q16_round(q);
      if (v > 16383) v = 16383;
      if (v < -16384) v = -16384;
      return v[POSITION_WIDTH-1:0];
   endfunction

   function automatic result_type predict_positions(pose_type p, int tool);
      longint c1, s1, c2, s2, c3, s3, c4, s4, c5, s5;
      longint px, py, u, v, wx, wy, wz;
      longint da, db, dc, a3, b3, du, dv, tx, ty, tz, len;
      result_type r;
      len = tool;
      trig_of(p.ang[0], c1, s1);
      trig_of(longint'(p.ang[1]) - 11520, c2, s2);   // joint 2 offset -90 deg
      trig_of(p.ang[2], c3, s3);
      trig_of(p.ang[3], c4, s4);
      trig_of(p.ang[4], c5, s5);
      px = 2208 * 65536 + 1408 * c3 - 2016 * s3;
      py = 1408 * s3 + 2016 * c3;
      u  = q16_round(c2 * px - s2 * py);
      v  = q16_round(s2 * px + c2 * py);
      wx = q16_round(c1 * u);
      wy = q16_round(s1 * u);
      wz = 2224 * 65536 - v;
      // tool axis
      da = -q16_round(c4 * s5);
      db = c5;
      dc = q16_round(s4 * s5);
      a3 = q16_round(c3 * da - s3 * db);
      b3 = q16_round(s3 * da + c3 * db);
      du = q16_round(c2 * a3 - s2 * b3);
      dv = q16_round(s2 * a3 + c2 * b3);
      tx = q16_round(c1 * du - s1 * dc);
      ty = q16_round(s1 * du + c1 * dc);
      tz = -dv;
      r.wrist_x = clamp_pos(wx);
      r.wrist_y = clamp_pos(wy);
      r.wrist_z = clamp_pos(wz);
      r.tip_x   = clamp_pos(wx + len * tx);
      r.tip_y   = clamp_pos(wy + len * ty);
      r.tip_z   = clamp_pos(wz + len * tz);
      return r;
   endfunction

   // ---------------------------------------------------------------- clock, limit
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("Timeout at %0t", $time);
      $display("forward_kinematics_dh6 verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- receiver
   // stalls at random per phase; a requested hold-off keeps tready low for a stretch
   initial begin
      rsp_tready = 0;
      @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[6*POSITION_WIDTH-1:0];
         result_count++;
         if (expected_positions.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            fail_count++;
         end else begin
            want = expected_positions.pop_front();
            if (got.wrist_x !== want.wrist_x) begin
               $display("%0t: wrist_x exp %0d got %0d", $time, want.wrist_x, got.wrist_x);
               fail_count++;
            end
            if (got.wrist_y !== want.wrist_y) begin
               $display("%0t: wrist_y exp %0d got %0d", $time, want.wrist_y, got.wrist_y);
               fail_count++;
            end
            if (got.wrist_z !== want.wrist_z) begin
               $display("%0t: wrist_z exp %0d got %0d", $time, want.wrist_z, got.wrist_z);
               fail_count++;
            end
            if (got.tip_x !== want.tip_x) begin
               $display("%0t: tip_x exp %0d got %0d", $time, want.tip_x, got.tip_x);
               fail_count++;
            end
            if (got.tip_y !== want.tip_y) begin
               $display("%0t: tip_y exp %0d got %0d", $time, want.tip_y, got.tip_y);
               fail_count++;
            end
            if (got.tip_z !== want.tip_z) begin
               $display("%0t: tip_z exp %0d got %0d", $time, want.tip_z, got.tip_z);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sender
   // Offers one request and holds it until accepted; random idle before it.
   // tvalid stays high after acceptance so back-to-back requests need no gap;
   // callers that pause drop it themselves.
   // Expectation is queued at acceptance with the current tool length.
   task automatic send_pose(pose_type p, bit has_fixed, result_type fixed);
      logic [REQ_WIDTH-1:0] word;
      word = '0;
      for (int j = 0; j < 6; j++) word[j*ANGLE_WIDTH +: ANGLE_WIDTH] = p.ang[j];
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tdata  <= word;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      expected_positions.push_back(has_fixed ? fixed : predict_positions(p, tool_len_model));
   endtask

   // Waits for the pipe to drain, then lets the latency pass before a register write.
   task automatic drain_pipe();
      req_tvalid <= 0;
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_tool(int len);
      drain_pipe();
      csr_wr_en   <= 1;
      csr_wr_data <= len[TOOL_WIDTH-1:0];
      @(posedge clock);
      csr_wr_en <= 0;
      tool_len_model = len;
   endtask

   function automatic int rand_angle(int mode);
      case (mode)
         0:       return $urandom_range(2 * ANG_MAX) - ANG_MAX;          // full legal range
         1:       return $urandom_range(2 * 11520) - 11520;              // +-90 degree working band
         2:       return ($urandom_range(1) ? ANG_MAX : -ANG_MAX) - $urandom_range(3) * 0;
         default: return int'($signed(17'($urandom)));                   // any 17-bit pattern
      endcase
   endfunction

   function automatic pose_type random_pose();
      pose_type p;
      int mode;
      mode = $urandom_range(9);
      for (int j = 0; j < 6; j++)
         p.ang[j] = ANGLE_WIDTH'(rand_angle(mode < 6 ? 1 : (mode < 8 ? 0 :
                                (mode == 8 ? 2 : 3))));
      return p;
   endfunction

   // directed table: extremes, quarter turns, wraparound and the joint 6 independence
   pose_row_type pose_rows [] = '{
      '{'{0, 0, 0, 0, 0, 0}, 0, '0},
      '{'{ANG_MAX, ANG_MAX, ANG_MAX, ANG_MAX, ANG_MAX, ANG_MAX}, 0, '0},
      '{'{-ANG_MAX, -ANG_MAX, -ANG_MAX, -ANG_MAX, -ANG_MAX, -ANG_MAX}, 0, '0},
      '{'{11520, 0, 0, 0, 0, 0}, 0, '0},
      '{'{-11520, 11520, 0, 0, 0, 0}, 0, '0},
      '{'{23040, 0, 11520, 0, 0, 0}, 0, '0},
      '{'{0, 23040, -11520, 11520, 11520, 0}, 0, '0},
      '{'{0, 0, 0, -11520, -11520, 0}, 0, '0},
      '{'{0, 0, 0, 0, 0, ANG_MAX}, 0, '0},
      '{'{0, 0, 0, 0, 0, -65536}, 0, '0},
      '{'{65535, -65536, 65535, -65536, 65535, 65535}, 0, '0},
      '{'{-65536, 65535, -65536, 65535, -65536, -1}, 0, '0},
      '{'{1, -1, 1, -1, 1, 1}, 0, '0},
      '{'{5760, 5760, 5760, 5760, 5760, 5760}, 0, '0},
      '{'{23040, -23040, 23039, -23039, 11521, 0}, 0, '0},
      '{'{46079, 46081, -46081, 0, 0, 0}, 0, '0}
   };

   int tool_settings [5] = '{0, 4095, 1, 2048, 1600};

   initial begin
      pose_type p;
      result_type none;
      int sent;
      reset = 1; req_tvalid = 0; req_tdata = '0; csr_wr_en = 0; csr_wr_data = '0;
      fail_count = 0; result_count = 0; sent = 0;
      send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
      tool_len_model = 0;
      none = '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed rows with tool length at its reset value, then at the maximum
      for (int t = 0; t < 2; t++) begin
         if (t == 1) write_tool(4095);
         foreach (pose_rows[k]) begin
            for (int j = 0; j < 6; j++) p.ang[j] = ANGLE_WIDTH'(pose_rows[k].a[j]);
            send_pose(p, pose_rows[k].has_fixed, pose_rows[k].fixed);
            sent++;
         end
      end

      // random phases: each tool setting, cycling through the idle mixes
      for (int ph = 0; ph < 8; ph++) begin
         write_tool(ph < 5 ? tool_settings[ph] : $urandom_range(4095));
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         // back-pressure: hold the receiver off long enough to fill the pipe
         if (ph == 2) hold_off_cycles <= 200;
         for (int n = 0; n < 200; n++) begin
            send_pose(random_pose(), 0, none);
            sent++;
            // sender pause until everything is back
            if (ph == 5 && n == 100) begin
               req_tvalid <= 0;
               while (expected_positions.size() != 0) @(posedge clock);
            end
         end
      end
      req_tvalid <= 0;

      while (expected_positions.size() != 0) @(posedge clock);
      repeat (LATENCY * 2) @(posedge clock);
      $display("Sent %0d pose requests over ten tool length settings incl. 0 and 4095, %0d results.",
               sent, result_count);
      $display("Idle mixes: none, sender, receiver, both; one long receiver hold-off.");
      if (fail_count == 0 && expected_positions.size() == 0)
         $display("forward_kinematics_dh6 verification clean");
      else
         $display("forward_kinematics_dh6 verification failed");
      $finish;
   end
endmodule
